### hw/rtl/vqtd_pkg.sv
package vqtd_pkg;

    localparam int TILE_COORD_BITS_DEF = 8;

    localparam int CMD_W     = 2;
    localparam int FMT_W     = 2;
    localparam int COORD_W   = 8;
    localparam int PIX_W     = 9;
    localparam int CH_W      = 8;
    localparam int ENTRY_W   = 8;
    localparam int CB_ADDR_W = 10;
    localparam int IDX_ADDR_W = 16;
    localparam int WORD_W    = 16;

    localparam logic [CMD_W-1:0] CMD_CB_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_IDX_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DECODE    = 2'd2;

    localparam logic [FMT_W-1:0] FMT_RGB565   = 2'd0;
    localparam logic [FMT_W-1:0] FMT_ARGB4444 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_ARGB1555 = 2'd2;

    localparam logic [CH_W-1:0] CH_FULL = 8'hff;

    typedef logic [CH_W-1:0] lut32_t [32];
    typedef logic [CH_W-1:0] lut64_t [64];

    typedef struct packed {
        logic [CH_W-1:0] alpha;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgba_t;

    // floor(v*255/31) and floor(v*255/63), worked out at elaboration
    function automatic lut32_t build_exp5();
        lut32_t lut;
        for (int i = 0; i < 32; i++)
        begin
            lut[i] = CH_W'((i * 255) / 31);
        end
        return lut;
    endfunction

    function automatic lut64_t build_exp6();
        lut64_t lut;
        for (int i = 0; i < 64; i++)
        begin
            lut[i] = CH_W'((i * 255) / 63);
        end
        return lut;
    endfunction

    localparam lut32_t EXP5_LUT = build_exp5();
    localparam lut64_t EXP6_LUT = build_exp6();

    // row bits land on even positions, column bits on odd ones
    function automatic logic [IDX_ADDR_W-1:0] morton(input logic [COORD_W-1:0] row,
                                                    input logic [COORD_W-1:0] col);
        logic [IDX_ADDR_W-1:0] addr;
        addr = '0;
        for (int i = 0; i < COORD_W; i++)
        begin
            addr[2*i]   = row[i];
            addr[2*i+1] = col[i];
        end
        return addr;
    endfunction

    function automatic rgba_t unpack(input logic [WORD_W-1:0] w, input logic [FMT_W-1:0] fmt);
        rgba_t p;
        case (fmt)
            FMT_ARGB4444:
            begin
                // v*255/15 is exactly v*17, i.e. the nibble repeated
                p.red   = {w[11:8], w[11:8]};
                p.green = {w[7:4], w[7:4]};
                p.blue  = {w[3:0], w[3:0]};
                p.alpha = {w[15:12], w[15:12]};
            end
            FMT_ARGB1555:
            begin
                p.red   = EXP5_LUT[w[14:10]];
                p.green = EXP5_LUT[w[9:5]];
                p.blue  = EXP5_LUT[w[4:0]];
                p.alpha = w[15] ? CH_FULL : '0;
            end
            default:
            begin
                p.red   = EXP5_LUT[w[15:11]];
                p.green = EXP6_LUT[w[10:5]];
                p.blue  = EXP5_LUT[w[4:0]];
                p.alpha = CH_FULL;
            end
        endcase
        return p;
    endfunction

endpackage

### hw/rtl/vq_twiddled_texture_decode.sv
// Decoder for vector-quantised, twiddled textures. Commands arrive as input beats: a codebook
// word write (1024 x 16-bit words, four texels per entry), an index map byte write (64 KiB)
// or a tile decode. A decode looks up the index byte at the Morton address of the tile (row in
// the even bits) and sends the entry's four texels out as RGBA8888, top-left, top-right,
// bottom-left, bottom-right, tlast on the fourth. Write beats give no output. A decode holds
// the codebook read port and issues one texel per cycle while the output does not stall;
// the path from the accepted beat to the first texel runs through index read, codebook read
// issue, codebook data and the unpack register. A decode or codebook write that follows a
// decode waits until that tile's four reads have been issued. Neither store is cleared at
// reset; the texel format register resets to RGB565 and the pipeline valid flags clear.
module vq_twiddled_texture_decode #(
    parameter int TILE_COORD_BITS = vqtd_pkg::TILE_COORD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,      // pixel_format

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // address[15:0], data[31:16], tile_row[39:32],
                                        // tile_col[47:40]
    input  logic [1:0]  s_axis_tuser,   // command

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // pixel_x[8:0], pixel_y[17:9], red[25:18],
                                        // green[33:26], blue[41:34], alpha[49:42], zero fill
    output logic        m_axis_tlast
);
    import vqtd_pkg::*;

    localparam int USED_BITS = (TILE_COORD_BITS < COORD_W) ? TILE_COORD_BITS : COORD_W;
    localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((1 << USED_BITS) - 1);

    // input beat fields
    logic                  accept_in;
    logic [CMD_W-1:0]      in_cmd;
    logic [IDX_ADDR_W-1:0] in_addr;
    logic [WORD_W-1:0]     in_data;
    logic [COORD_W-1:0]    in_row;
    logic [COORD_W-1:0]    in_col;

    logic [FMT_W-1:0]      fmt_reg;

    // stage a: index map access
    logic                  a_valid_reg, a_valid_next;
    logic [CMD_W-1:0]      a_cmd_reg;
    logic [CB_ADDR_W-1:0]  a_addr_reg;
    logic [WORD_W-1:0]     a_data_reg;
    logic [COORD_W-1:0]    a_row_reg;
    logic [COORD_W-1:0]    a_col_reg;
    logic [ENTRY_W-1:0]    idx_rdata_reg;
    logic                  a_adv;
    logic                  a_needs_b;

    // stage b: texel sequencer on the codebook read port
    logic                  b_busy_reg, b_busy_next;
    logic [1:0]            b_cnt_reg, b_cnt_next;
    logic [ENTRY_W-1:0]    b_entry_reg;
    logic [COORD_W-1:0]    b_row_reg;
    logic [COORD_W-1:0]    b_col_reg;
    logic                  b_issue;
    logic                  b_done;
    logic                  b_free;

    // stage c: codebook data
    logic                  c_valid_reg, c_valid_next;
    logic [WORD_W-1:0]     cb_rdata_reg;
    logic [PIX_W-1:0]      c_x_reg;
    logic [PIX_W-1:0]      c_y_reg;
    logic                  c_last_reg;
    logic                  c_ready;

    // stage d: output register
    logic                  d_valid_reg, d_valid_next;
    logic [PIX_W-1:0]      d_x_reg;
    logic [PIX_W-1:0]      d_y_reg;
    rgba_t                 d_pix_reg;
    logic                  d_last_reg;
    logic                  d_ready;

    logic [WORD_W-1:0]     codebook [1 << CB_ADDR_W];
    logic [ENTRY_W-1:0]    index_map [1 << IDX_ADDR_W];

    assign in_cmd  = s_axis_tuser;
    assign in_addr = s_axis_tdata[15:0];
    assign in_data = s_axis_tdata[31:16];
    assign in_row  = s_axis_tdata[39:32] & COORD_MASK;
    assign in_col  = s_axis_tdata[47:40] & COORD_MASK;

    assign accept_in = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_RGB565;
        end
        else if (cfg_we)
        begin
            fmt_reg <= cfg_wdata;
        end
    end

    // handshake chain, back to front
    assign d_ready = !d_valid_reg || m_axis_tready;
    assign c_ready = !c_valid_reg || d_ready;
    assign b_issue = b_busy_reg && c_ready;
    assign b_done  = b_issue && (b_cnt_reg == 2'd3);
    assign b_free  = !b_busy_reg || b_done;

    // decodes and codebook writes both go through the codebook port in order
    assign a_needs_b = (a_cmd_reg == CMD_DECODE) || (a_cmd_reg == CMD_CB_WRITE);
    assign a_adv     = a_valid_reg && (!a_needs_b || b_free);

    assign s_axis_tready = !a_valid_reg || a_adv;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept_in)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_adv)
        begin
            a_valid_next = 1'b0;
        end

        b_busy_next = b_busy_reg;
        b_cnt_next  = b_cnt_reg;
        if (a_adv && (a_cmd_reg == CMD_DECODE))
        begin
            b_busy_next = 1'b1;
            b_cnt_next  = 2'd0;
        end
        else if (b_issue)
        begin
            b_cnt_next = b_cnt_reg + 2'd1;
            if (b_done)
            begin
                b_busy_next = 1'b0;
            end
        end

        c_valid_next = c_ready ? b_issue : c_valid_reg;
        d_valid_next = d_ready ? c_valid_reg : d_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_busy_reg  <= 1'b0;
            b_cnt_reg   <= 2'd0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_busy_reg  <= b_busy_next;
            b_cnt_reg   <= b_cnt_next;
            c_valid_reg <= c_valid_next;
            d_valid_reg <= d_valid_next;
        end
    end

    // index map: writes and lookups both at input acceptance, so order holds
    always_ff @(posedge clk)
    begin
        if (accept_in && (in_cmd == CMD_IDX_WRITE))
        begin
            index_map[in_addr] <= in_data[ENTRY_W-1:0];
        end
        if (accept_in && (in_cmd == CMD_DECODE))
        begin
            idx_rdata_reg <= index_map[morton(in_row, in_col)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            a_cmd_reg  <= in_cmd;
            a_addr_reg <= in_addr[CB_ADDR_W-1:0];
            a_data_reg <= in_data;
            a_row_reg  <= in_row;
            a_col_reg  <= in_col;
        end
        if (a_adv && (a_cmd_reg == CMD_DECODE))
        begin
            b_entry_reg <= idx_rdata_reg;
            b_row_reg   <= a_row_reg;
            b_col_reg   <= a_col_reg;
        end
    end

    // texel k uses word {k[0], k[1]} of the entry: 0, 2, 1, 3
    always_ff @(posedge clk)
    begin
        if (a_adv && (a_cmd_reg == CMD_CB_WRITE))
        begin
            codebook[a_addr_reg] <= a_data_reg;
        end
        if (b_issue)
        begin
            cb_rdata_reg <= codebook[{b_entry_reg, b_cnt_reg[0], b_cnt_reg[1]}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_issue)
        begin
            c_x_reg    <= {b_col_reg, b_cnt_reg[0]};
            c_y_reg    <= {b_row_reg, b_cnt_reg[1]};
            c_last_reg <= (b_cnt_reg == 2'd3);
        end
        if (c_valid_reg && d_ready)
        begin
            d_x_reg    <= c_x_reg;
            d_y_reg    <= c_y_reg;
            d_pix_reg  <= unpack(cb_rdata_reg, fmt_reg);
            d_last_reg <= c_last_reg;
        end
    end

    assign m_axis_tvalid = d_valid_reg;
    assign m_axis_tlast  = d_last_reg;
    assign m_axis_tdata  = {6'd0, d_pix_reg.alpha, d_pix_reg.blue, d_pix_reg.green,
                            d_pix_reg.red, d_y_reg, d_x_reg};

    // the fourth texel of a tile is always the bottom-right one
    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[0] && m_axis_tdata[9]))
        else $error("last texel is not the bottom-right corner");

    // a stalled sequencer neither advances nor drops its tile
    a_seq_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (b_busy_reg && !c_ready) |=> (b_busy_reg && $stable(b_cnt_reg)))
        else $error("texel sequencer moved while stalled");

    // codebook data held while the output side stalls
    a_cb_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && !d_ready) |=> (c_valid_reg && $stable(cb_rdata_reg)))
        else $error("codebook data lost under stall");

endmodule

### tb/vq_twiddled_texture_decode_test.sv
module vq_twiddled_texture_decode_test;

    timeunit 1ns;
    timeprecision 1ps;

    import vqtd_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;
    localparam logic [FMT_W-1:0] FMT_SPARE = 2'd3;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int CFG_TAIL     = 8;
    localparam int END_TAIL     = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_BEATS  = 56;

    typedef struct packed {
        logic [PIX_W-1:0] pix_x;
        logic [PIX_W-1:0] pix_y;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  alpha;
        logic             last;
    } texel_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } tile_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_wdata = '0;         // pixel_format
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;      // address, data, tile_row, tile_col
    logic [1:0]  s_axis_tuser = '0;      // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;           // pixel_x, pixel_y, red, green, blue, alpha, zero fill
    logic        m_axis_tlast;

    // shadow copy of the block's stores and format
    logic [WORD_W-1:0]  cb_shadow [1024];
    bit                 cb_known [1024];
    logic [ENTRY_W-1:0] idx_shadow [65536];
    bit                 idx_known [65536];
    logic [FMT_W-1:0]   fmt_now = FMT_RGB565;

    texel_t texels_due [$];
    tile_t  decodable_tiles [$];

    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int          beats_taken = 0;
    int          sink_hold_cycles = 0;
    int          sink_pause = 0;
    bit          idling = 1'b0;

    vq_twiddled_texture_decode dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // spread the low 16 bits of v onto the even bit positions
    function automatic logic [31:0] spread_even(input logic [31:0] v);
        v &= 32'h0000_FFFF;
        v = (v | (v << 8)) & 32'h00FF_00FF;
        v = (v | (v << 4)) & 32'h0F0F_0F0F;
        v = (v | (v << 2)) & 32'h3333_3333;
        v = (v | (v << 1)) & 32'h5555_5555;
        return v;
    endfunction

    function automatic logic [IDX_ADDR_W-1:0] twiddle(input logic [COORD_W-1:0] row,
                                                      input logic [COORD_W-1:0] col);
        logic [31:0] a;
        a = spread_even(32'(row)) | (spread_even(32'(col)) << 1);
        return a[IDX_ADDR_W-1:0];
    endfunction

    function automatic logic [CH_W-1:0] stretch_channel(input int v, input int top);
        return CH_W'((v * 255) / top);
    endfunction

    function automatic texel_t shade_texel(input logic [WORD_W-1:0] w);
        texel_t t;
        t = '0;
        case (fmt_now)
            FMT_ARGB4444:
            begin
                t.red   = stretch_channel(w[11:8], 15);
                t.green = stretch_channel(w[7:4], 15);
                t.blue  = stretch_channel(w[3:0], 15);
                t.alpha = stretch_channel(w[15:12], 15);
            end
            FMT_ARGB1555:
            begin
                t.red   = stretch_channel(w[14:10], 31);
                t.green = stretch_channel(w[9:5], 31);
                t.blue  = stretch_channel(w[4:0], 31);
                t.alpha = w[15] ? 8'hff : 8'h00;
            end
            default:
            begin
                // the spare format code falls back to 565
                t.red   = stretch_channel(w[15:11], 31);
                t.green = stretch_channel(w[10:5], 63);
                t.blue  = stretch_channel(w[4:0], 31);
                t.alpha = 8'hff;
            end
        endcase
        return t;
    endfunction

    function automatic bit tile_ready(input logic [COORD_W-1:0] row,
                                      input logic [COORD_W-1:0] col);
        logic [IDX_ADDR_W-1:0] a;
        logic [ENTRY_W-1:0]    e;
        a = twiddle(row, col);
        if (!idx_known[a])
            return 1'b0;
        e = idx_shadow[a];
        return cb_known[{e, 2'd0}] && cb_known[{e, 2'd1}] &&
               cb_known[{e, 2'd2}] && cb_known[{e, 2'd3}];
    endfunction

    function automatic void predict_tile(input logic [COORD_W-1:0] row,
                                         input logic [COORD_W-1:0] col);
        logic [ENTRY_W-1:0] e;
        logic [1:0]         k;
        texel_t             t;
        e = idx_shadow[twiddle(row, col)];
        for (int i = 0; i < 4; i++)
        begin
            k = 2'(i);
            // codebook words go out 0, 2, 1, 3: the entry is stored column first
            t = shade_texel(cb_shadow[{e, k[0], k[1]}]);
            t.pix_x = {col, k[0]};
            t.pix_y = {row, k[1]};
            t.last  = (i == 3);
            texels_due.push_back(t);
        end
    endfunction

    function automatic void apply_beat(input logic [CMD_W-1:0] cmd,
                                       input logic [15:0] addr,
                                       input logic [15:0] data,
                                       input logic [COORD_W-1:0] row,
                                       input logic [COORD_W-1:0] col);
        case (cmd)
            CMD_CB_WRITE:
            begin
                cb_shadow[addr[CB_ADDR_W-1:0]] = data;
                cb_known[addr[CB_ADDR_W-1:0]]  = 1'b1;
            end
            CMD_IDX_WRITE:
            begin
                idx_shadow[addr] = data[ENTRY_W-1:0];
                idx_known[addr]  = 1'b1;
            end
            CMD_DECODE:
                predict_tile(row, col);
            default:
                ;
        endcase
        if (cmd != CMD_NOP)
            beats_taken++;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idling)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic push_beat(input logic [CMD_W-1:0] cmd,
                             input logic [15:0] addr,
                             input logic [15:0] data,
                             input logic [COORD_W-1:0] row,
                             input logic [COORD_W-1:0] col);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {col, row, data, addr};
        do
            @(posedge clk);
        while (!s_axis_tready);
        apply_beat(cmd, addr, data, row, col);
    endtask

    task automatic load_word(input logic [15:0] addr, input logic [15:0] data);
        push_beat(CMD_CB_WRITE, addr, data, 8'($urandom), 8'($urandom));
    endtask

    task automatic load_index(input logic [15:0] addr, input logic [15:0] data);
        push_beat(CMD_IDX_WRITE, addr, data, 8'($urandom), 8'($urandom));
    endtask

    task automatic decode_tile(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col);
        push_beat(CMD_DECODE, 16'($urandom), 16'($urandom), row, col);
    endtask

    task automatic settle(input int tail);
        s_axis_tvalid <= 1'b0;
        while (texels_due.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic set_format(input logic [FMT_W-1:0] fmt);
        settle(CFG_TAIL);
        cfg_we    <= 1'b1;
        cfg_wdata <= fmt;
        @(posedge clk);
        cfg_we  <= 1'b0;
        fmt_now = fmt;
    endtask

    // receiver: random stalls, plus a long hold when a test asks for one
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (sink_hold_cycles > 0)
        begin
            sink_hold_cycles--;
            m_axis_tready <= 1'b0;
        end
        else if (sink_pause > 0)
        begin
            sink_pause--;
            m_axis_tready <= 1'b0;
        end
        else if (idling && $urandom_range(0, 99) < 20)
        begin
            sink_pause = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                      : $urandom_range(9, 49);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    function automatic void check_field(input string what,
                                        input logic [8:0] want,
                                        input logic [8:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %h, got %h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : texel_check
        texel_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (texels_due.size() == 0)
            begin
                $display("%0t ns: texel beat with none due, expected nothing, got %h",
                         $time, m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = texels_due.pop_front();
                check_field("pixel_x", want.pix_x, m_axis_tdata[8:0]);
                check_field("pixel_y", want.pix_y, m_axis_tdata[17:9]);
                check_field("red", want.red, m_axis_tdata[25:18]);
                check_field("green", want.green, m_axis_tdata[33:26]);
                check_field("blue", want.blue, m_axis_tdata[41:34]);
                check_field("alpha", want.alpha, m_axis_tdata[49:42]);
                check_field("zero fill", '0, m_axis_tdata[55:50]);
                check_field("tlast", want.last, m_axis_tlast);
            end
        end
    end

    // format is 565 out of reset; entry 0 holds black, white, pure red, pure green
    task automatic test_reset_format();
        load_word(16'h0000, 16'h0000);
        load_word(16'h0001, 16'hFFFF);
        load_word(16'h0002, 16'hF800);
        load_word(16'h0003, 16'h07E0);
        load_index(twiddle(8'h00, 8'h00), 16'hFF00);
        decode_tile(8'h00, 8'h00);
        decodable_tiles.push_back('{row: 8'h00, col: 8'h00});
    endtask

    // entry 255 written through wrapped addresses, tiles at the corners of the map
    task automatic test_coordinate_extremes();
        load_word(16'hFFFC, 16'h001F);
        load_word(16'hFFFD, 16'h8000);
        load_word(16'hFFFE, 16'h7FFF);
        load_word(16'hFFFF, 16'h5A5A);
        load_index(twiddle(8'hFF, 8'hFF), 16'h00FF);
        decode_tile(8'hFF, 8'hFF);
        load_index(twiddle(8'hFF, 8'h00), 16'h1200);
        decode_tile(8'hFF, 8'h00);
        load_index(twiddle(8'h00, 8'hFF), 16'hFFFF);
        decode_tile(8'h00, 8'hFF);
        decodable_tiles.push_back('{row: 8'hFF, col: 8'hFF});
        decodable_tiles.push_back('{row: 8'hFF, col: 8'h00});
        decodable_tiles.push_back('{row: 8'h00, col: 8'hFF});
    endtask

    // the spare command must neither write nor produce texels
    task automatic test_ignored_command();
        push_beat(CMD_NOP, 16'h0000, 16'hFFFF, 8'h00, 8'h00);
        decode_tile(8'h00, 8'h00);
    endtask

    task automatic test_pixel_formats();
        logic [FMT_W-1:0] order [4];
        order = '{FMT_ARGB4444, FMT_ARGB1555, FMT_SPARE, FMT_RGB565};
        foreach (order[i])
        begin
            set_format(order[i]);
            decode_tile(8'h00, 8'h00);
            decode_tile(8'hFF, 8'hFF);
        end
    endtask

    task automatic test_random_traffic(input int beats, input bit with_gaps);
        int                 stop_at;
        int                 pick;
        int                 start;
        int                 step;
        tile_t              t;
        tile_t              u;
        logic [ENTRY_W-1:0] e;
        idling = with_gaps;
        set_format(FMT_W'($urandom_range(0, 3)));
        stop_at = beats_taken + beats;
        while (beats_taken < stop_at)
        begin
            pick = $urandom_range(0, 99);
            t = decodable_tiles[$urandom_range(0, decodable_tiles.size() - 1)];
            u = decodable_tiles[$urandom_range(0, decodable_tiles.size() - 1)];
            if (pick < 45)
            begin
                // fresh entry in a shuffled word order, pointed at from a random tile
                e = 8'($urandom);
                start = $urandom_range(0, 3);
                step = $urandom_range(0, 1) ? 1 : 3;
                for (int i = 0; i < 4; i++)
                    load_word({6'($urandom), e, 2'(start + i * step)}, 16'($urandom));
                t.row = 8'($urandom);
                t.col = 8'($urandom);
                load_index(twiddle(t.row, t.col), {8'($urandom), e});
                decode_tile(t.row, t.col);
                decodable_tiles.push_back(t);
            end
            else if (pick < 70)
            begin
                if (tile_ready(t.row, t.col))
                    decode_tile(t.row, t.col);
            end
            else if (pick < 85)
            begin
                // rewrite the stores right behind a decode that reads them
                if (tile_ready(t.row, t.col) && tile_ready(u.row, u.col))
                begin
                    e = idx_shadow[twiddle(t.row, t.col)];
                    decode_tile(t.row, t.col);
                    load_word({6'($urandom), e, 2'($urandom)}, 16'($urandom));
                    load_index(twiddle(t.row, t.col),
                               {8'($urandom), idx_shadow[twiddle(u.row, u.col)]});
                    decode_tile(t.row, t.col);
                end
            end
            else if (pick < 92)
                load_index(16'($urandom), 16'($urandom));
            else if (pick < 97)
                load_word(16'($urandom), 16'($urandom));
            else
                push_beat(CMD_NOP, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    // receiver goes quiet while decodes keep coming, so the block backs up
    task automatic test_output_hold();
        tile_t t;
        idling = 1'b0;
        sink_hold_cycles = HOLD_CYCLES;
        repeat (30)
        begin
            t = decodable_tiles[$urandom_range(0, decodable_tiles.size() - 1)];
            if (tile_ready(t.row, t.col))
                decode_tile(t.row, t.col);
        end
        settle(CFG_TAIL);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_format();
        test_coordinate_extremes();
        test_ignored_command();
        test_pixel_formats();
        for (int phase = 0; phase < 6; phase++)
            test_random_traffic(PHASE_BEATS, phase != 0);
        test_output_hold();

        settle(END_TAIL);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
